// ----- src/tks_pkg.sv -----
// ----------------------------------------------------------------------------
// tks_pkg
// Shared constants and controller/datapath interface types for the top-k
// score table.
// ----------------------------------------------------------------------------
package tks_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int CAP_W       = 5;
   localparam int CMP_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int KEY_W       = 32;
   localparam int SCORE_W     = 16;
   localparam int IDX_W       = 4;
   localparam int RANK_W      = 5;

   localparam logic CMD_UPDATE = 1'b0;
   localparam logic CMD_READ   = 1'b1;

   typedef struct packed {
      logic capture;
      logic merge;
      logic place;
      logic read_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_read;
      logic out_free;
   } ctrl_stat_type;

endpackage

// ----- src/tks_ctrl.sv -----
// ----------------------------------------------------------------------------
// tks_ctrl
// Sequencer for the top-k score table: accepts one item, then steps the
// datapath through merge and place (update) or a single read.
// ----------------------------------------------------------------------------
module tks_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  tks_pkg::ctrl_stat_type stat,
   output tks_pkg::ctrl_cmd_type  cmd
);
   import tks_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_READ  = 4'b0010,
      ST_MERGE = 4'b0100,
      ST_PLACE = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_MERGE;
            end
         end
         ST_MERGE: begin
            if (stat.is_read) begin
               state_in = ST_READ;
            end else begin
               cmd.merge = 1'b1;
               state_in  = ST_PLACE;
            end
         end
         ST_READ: begin
            if (stat.out_free) begin
               cmd.read_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_PLACE: begin
            if (stat.out_free) begin
               cmd.place = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- src/tks_datapath.sv -----
// ----------------------------------------------------------------------------
// tks_datapath
// Entry table, capacity register, item registers and result register.
// Merge removes a matching key; place inserts by a parallel compare and a
// one-position shift.
// ----------------------------------------------------------------------------
module tks_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  tks_pkg::ctrl_cmd_type               cmd,
   output tks_pkg::ctrl_stat_type              stat,
   input  logic                                req_command,
   input  logic [tks_pkg::KEY_W-1:0]           req_entry_key,
   input  logic signed [tks_pkg::SCORE_W-1:0]  req_entry_score,
   input  logic [tks_pkg::IDX_W-1:0]           req_read_index,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tks_pkg::CAP_W-1:0]           csr_capacity_limit,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [tks_pkg::RANK_W-1:0]          rsp_placed_rank,
   output logic [tks_pkg::KEY_W-1:0]           rsp_out_key,
   output logic signed [tks_pkg::SCORE_W-1:0]  rsp_out_score,
   output logic                                rsp_out_valid
);
   import tks_pkg::*;

   logic [KEY_W-1:0]          key_ff   [TABLE_DEPTH];
   logic [KEY_W-1:0]          key_in   [TABLE_DEPTH];
   logic signed [SCORE_W-1:0] score_ff [TABLE_DEPTH];
   logic signed [SCORE_W-1:0] score_in [TABLE_DEPTH];
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CAP_W-1:0]          cap_ff;

   logic                      cmd_ff;
   logic [KEY_W-1:0]          ikey_ff;
   logic signed [SCORE_W-1:0] iscore_ff, iscore_in;
   logic [IDX_W-1:0]          idx_ff;

   logic                      rvalid_ff, rvalid_in;
   logic [RANK_W-1:0]         rank_ff, rank_in;
   logic [KEY_W-1:0]          okey_ff, okey_in;
   logic signed [SCORE_W-1:0] oscore_ff, oscore_in;
   logic                      ovalid_ff, ovalid_in;

   logic [CNT_W-1:0]          eff_cap;
   logic                      out_free;

   assign csr_ready = 1'b1;
   assign out_free  = !rvalid_ff || !rsp_stall;
   assign eff_cap   = (CMP_W'(cap_ff) > CMP_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                              : CNT_W'(cap_ff);

   assign stat.is_read  = (cmd_ff == CMD_READ);
   assign stat.out_free = out_free;

   assign rsp_valid       = rvalid_ff;
   assign rsp_placed_rank = rank_ff;
   assign rsp_out_key     = okey_ff;
   assign rsp_out_score   = oscore_ff;
   assign rsp_out_valid   = ovalid_ff;

   always_comb begin
      logic             mfound;
      logic             pfound;
      logic             drop;
      logic [CNT_W-1:0] pos;
      logic [CNT_W-1:0] clamp;
      logic             ge [TABLE_DEPTH];

      key_in    = key_ff;
      score_in  = score_ff;
      count_in  = count_ff;
      iscore_in = iscore_ff;
      rvalid_in = rvalid_ff && rsp_stall;
      rank_in   = rank_ff;
      okey_in   = okey_ff;
      oscore_in = oscore_ff;
      ovalid_in = ovalid_ff;
      mfound    = 1'b0;
      pfound    = 1'b0;
      pos       = count_ff;
      drop      = 1'b0;
      clamp     = eff_cap;

      // merge: take out a matching key, keep the larger score
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (!mfound && (CNT_W'(i) < count_ff) && (key_ff[i] == ikey_ff)) begin
            mfound = 1'b1;
            if (score_ff[i] > iscore_ff) begin
               iscore_in = score_ff[i];
            end
         end
         ge[i] = mfound;
      end

      // place: first slot with a strictly lower score
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (!pfound && (CNT_W'(i) < count_ff) && (iscore_ff > score_ff[i])) begin
            pfound = 1'b1;
            pos    = CNT_W'(i);
         end
      end
      drop = (pos >= eff_cap);

      if (cmd.merge) begin
         for (int i = 0; i + 1 < TABLE_DEPTH; i++) begin
            if (ge[i]) begin
               key_in[i]   = key_ff[i + 1];
               score_in[i] = score_ff[i + 1];
            end
         end
         if (mfound) begin
            count_in = count_ff - CNT_W'(1);
         end
      end

      if (cmd.place) begin
         rvalid_in = 1'b1;
         okey_in   = '0;
         oscore_in = '0;
         ovalid_in = 1'b0;
         if (drop) begin
            rank_in = RANK_W'(TABLE_DEPTH);
         end else begin
            rank_in = RANK_W'(pos);
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               if (CNT_W'(i) == pos) begin
                  key_in[i]   = ikey_ff;
                  score_in[i] = iscore_ff;
               end else if ((i > 0) && (CNT_W'(i) > pos)) begin
                  key_in[i]   = key_ff[i - 1];
                  score_in[i] = score_ff[i - 1];
               end
            end
            count_in = (count_ff < eff_cap) ? count_ff + CNT_W'(1) : eff_cap;
         end
      end

      if (cmd.read_out) begin
         rvalid_in = 1'b1;
         rank_in   = '0;
         okey_in   = '0;
         oscore_in = '0;
         ovalid_in = 1'b0;
         if (32'(idx_ff) < 32'(count_ff)) begin
            ovalid_in = 1'b1;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               if (32'(idx_ff) == i) begin
                  okey_in   = key_ff[i];
                  oscore_in = score_ff[i];
               end
            end
         end
      end

      // capacity write: clamp to the new effective capacity
      if (csr_valid) begin
         clamp = (CMP_W'(csr_capacity_limit) > CMP_W'(TABLE_DEPTH))
               ? CNT_W'(TABLE_DEPTH) : CNT_W'(csr_capacity_limit);
         if (count_ff > clamp) begin
            count_in = clamp;
         end
      end

      if (cmd.capture) begin
         iscore_in = req_entry_score;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         cap_ff    <= CAP_W'(16);
         rvalid_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         rvalid_ff <= rvalid_in;
         if (csr_valid) begin
            cap_ff <= csr_capacity_limit;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff    <= key_in;
      score_ff  <= score_in;
      iscore_ff <= iscore_in;
      rank_ff   <= rank_in;
      okey_ff   <= okey_in;
      oscore_ff <= oscore_in;
      ovalid_ff <= ovalid_in;
      if (cmd.capture) begin
         cmd_ff  <= req_command;
         ikey_ff <= req_entry_key;
         idx_ff  <= req_read_index;
      end
   end

endmodule

// ----- src/top_k_score_table.sv -----
// ----------------------------------------------------------------------------
// top_k_score_table
// Leaderboard of up to 16 (key, score) entries in descending score order.
// ----------------------------------------------------------------------------
// One item at a time. An update runs the merge of a matching key, then
// placement by a parallel compare and a one-position shift; a read fetches
// one entry. A new item is not taken until the last one is through. The
// next item is taken once the result is loaded into the output register,
// so a pending result does not hold off the next transfer. The user must
// write the capacity register only while the block is idle; the block does
// not enforce it. Lowering the capacity drops the lowest entries at once.
// ----------------------------------------------------------------------------
module top_k_score_table (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_command,
   input  logic [tks_pkg::KEY_W-1:0]           req_entry_key,
   input  logic signed [tks_pkg::SCORE_W-1:0]  req_entry_score,
   input  logic [tks_pkg::IDX_W-1:0]           req_read_index,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [tks_pkg::RANK_W-1:0]          rsp_placed_rank,
   output logic [tks_pkg::KEY_W-1:0]           rsp_out_key,
   output logic signed [tks_pkg::SCORE_W-1:0]  rsp_out_score,
   output logic                                rsp_out_valid,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tks_pkg::CAP_W-1:0]           csr_capacity_limit
);
   import tks_pkg::*;

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;

   tks_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   tks_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_command        (req_command),
      .req_entry_key      (req_entry_key),
      .req_entry_score    (req_entry_score),
      .req_read_index     (req_read_index),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_capacity_limit (csr_capacity_limit),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_placed_rank    (rsp_placed_rank),
      .rsp_out_key        (rsp_out_key),
      .rsp_out_score      (rsp_out_score),
      .rsp_out_valid      (rsp_out_valid)
   );

endmodule

// ----- bench/tb_top_k_score_table.sv -----
// ----------------------------------------------------------------------------
// tb_top_k_score_table
// Self-checking bench for the top-k score table. A short scripted sequence
// covers the field extremes, key merges, equal-score ordering, entries that
// drop off and capacity changes; random traffic over a small key pool then
// keeps the table full and churning at several capacities. Every result
// transfer is checked against the in-bench leaderboard model or a typed reply.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top_k_score_table;
   import tks_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int RANDOM_PHASES   = 9;
   localparam int ITEMS_PER_PHASE = 206;
   localparam int KEY_POOL_SIZE   = 24;
   localparam int SETTLE_CYCLES   = 20;
   localparam int SCRIPT_SLOTS    = 32;
   localparam int REPLY_PTR_W     = 3;
   localparam int REPLY_SLOTS     = 1 << REPLY_PTR_W;
   localparam logic [RANK_W-1:0] DROPPED_RANK = RANK_W'(TABLE_DEPTH);

   typedef enum logic {ROW_REQUEST, ROW_CAPACITY} row_kind_type;

   typedef struct packed {
      logic                      command;
      logic [KEY_W-1:0]          entry_key;
      logic signed [SCORE_W-1:0] entry_score;
      logic [IDX_W-1:0]          read_index;
   } board_request_type;

   typedef struct packed {
      logic [RANK_W-1:0]         placed_rank;
      logic [KEY_W-1:0]          out_key;
      logic signed [SCORE_W-1:0] out_score;
      logic                      out_valid;
   } board_reply_type;

   typedef struct packed {
      row_kind_type      kind;
      board_request_type request;
      logic [CAP_W-1:0]  capacity;
      logic              typed;
      board_reply_type   reply;
   } script_row_type;

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_command = CMD_UPDATE;
   logic [KEY_W-1:0]          req_entry_key = '0;
   logic signed [SCORE_W-1:0] req_entry_score = '0;
   logic [IDX_W-1:0]          req_read_index = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [RANK_W-1:0]         rsp_placed_rank;
   logic [KEY_W-1:0]          rsp_out_key;
   logic signed [SCORE_W-1:0] rsp_out_score;
   logic                      rsp_out_valid;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CAP_W-1:0]          csr_capacity_limit = '0;

   int          sender_idle_pct   = 32;
   int          receiver_idle_pct = 58;
   int          mismatch_count    = 0;
   int unsigned cycles_run        = 0;

   // leaderboard model state
   logic [KEY_W-1:0]          board_key [TABLE_DEPTH];
   logic signed [SCORE_W-1:0] board_score [TABLE_DEPTH];
   int                        board_count = 0;
   logic [CAP_W-1:0]          board_cap = CAP_W'(16);
   board_reply_type           awaited_replies [REPLY_SLOTS];
   logic [REPLY_PTR_W-1:0]    reply_head = '0;
   logic [REPLY_PTR_W-1:0]    reply_tail = '0;
   logic [KEY_W-1:0]          key_pool [KEY_POOL_SIZE];
   script_row_type            directed_script [SCRIPT_SLOTS];
   int                        script_rows = 0;

   top_k_score_table i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_entry_key      (req_entry_key),
      .req_entry_score    (req_entry_score),
      .req_read_index     (req_read_index),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_placed_rank    (rsp_placed_rank),
      .rsp_out_key        (rsp_out_key),
      .rsp_out_score      (rsp_out_score),
      .rsp_out_valid      (rsp_out_valid),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_capacity_limit (csr_capacity_limit)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles_run <= cycles_run + 1;
   end

   initial begin : watchdog
      wait (cycles_run >= CYCLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic int usable_capacity();
      return (int'(board_cap) > TABLE_DEPTH) ? TABLE_DEPTH : int'(board_cap);
   endfunction

   function automatic board_reply_type board_apply(input board_request_type q);
      board_reply_type           r;
      logic signed [SCORE_W-1:0] s;
      int                        lim;
      int                        n;
      int                        slot;
      int                        pos;
      int                        last;
      r = '0;
      if (q.command == CMD_READ) begin
         if (int'(q.read_index) < board_count) begin
            r.out_key   = board_key[q.read_index];
            r.out_score = board_score[q.read_index];
            r.out_valid = 1'b1;
         end
         return r;
      end
      lim  = usable_capacity();
      s    = q.entry_score;
      n    = board_count;
      slot = n;
      for (int i = 0; i < n; i++)
         if (slot == n && board_key[i] == q.entry_key) slot = i;
      // same key: keep the larger score and take the entry out
      if (slot < n) begin
         if (board_score[slot] > s) s = board_score[slot];
         for (int i = slot; i < n - 1; i++) begin
            board_key[i]   = board_key[i + 1];
            board_score[i] = board_score[i + 1];
         end
         n--;
      end
      pos = n;
      for (int i = 0; i < n; i++)
         if (pos == n && s > board_score[i]) pos = i;
      if (pos >= lim) begin
         board_count   = n;
         r.placed_rank = DROPPED_RANK;
         return r;
      end
      last = (n < lim) ? n : lim - 1;
      for (int i = last; i > pos; i--) begin
         board_key[i]   = board_key[i - 1];
         board_score[i] = board_score[i - 1];
      end
      board_key[pos]   = q.entry_key;
      board_score[pos] = s;
      board_count      = (n < lim) ? n + 1 : lim;
      r.placed_rank    = RANK_W'(pos);
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("%0t mismatch: %s", $time, what);
   endtask

   always @(posedge clock) begin
      board_reply_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (reply_head == reply_tail) begin
            report_mismatch("result transfer with no request outstanding");
         end else begin
            want       = awaited_replies[reply_head];
            reply_head = reply_head + REPLY_PTR_W'(1);
            if (rsp_placed_rank !== want.placed_rank)
               report_mismatch($sformatf("placed_rank %0d, predicted %0d",
                                         rsp_placed_rank, want.placed_rank));
            if (rsp_out_key !== want.out_key)
               report_mismatch($sformatf("out_key %h, predicted %h",
                                         rsp_out_key, want.out_key));
            if (rsp_out_score !== want.out_score)
               report_mismatch($sformatf("out_score %0d, predicted %0d",
                                         rsp_out_score, want.out_score));
            if (rsp_out_valid !== want.out_valid)
               report_mismatch($sformatf("out_valid %b, predicted %b",
                                         rsp_out_valid, want.out_valid));
         end
      end
      rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
   end

   task automatic send_request(input board_request_type q, input logic typed,
                               input board_reply_type typed_reply);
      board_reply_type predicted;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= q.command;
      req_entry_key   <= q.entry_key;
      req_entry_score <= q.entry_score;
      req_read_index  <= q.read_index;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = board_apply(q);
      awaited_replies[reply_tail] = typed ? typed_reply : predicted;
      reply_tail = reply_tail + REPLY_PTR_W'(1);
   endtask

   task automatic settle_board();
      req_valid <= 1'b0;
      while (reply_head != reply_tail) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] value);
      settle_board();
      csr_valid          <= 1'b1;
      csr_capacity_limit <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      board_cap = value;
      if (board_count > usable_capacity()) board_count = usable_capacity();
   endtask

   function automatic void add_row(input script_row_type row);
      directed_script[script_rows] = row;
      script_rows++;
   endfunction

   function automatic script_row_type update_row(input logic [KEY_W-1:0] key,
                                                 input logic signed [SCORE_W-1:0] score);
      script_row_type r;
      r = '0;
      r.kind                = ROW_REQUEST;
      r.request.command     = CMD_UPDATE;
      r.request.entry_key   = key;
      r.request.entry_score = score;
      return r;
   endfunction

   // unused key and score fields carry all ones on reads
   function automatic script_row_type read_row(input logic [IDX_W-1:0] index);
      script_row_type r;
      r = '0;
      r.kind                = ROW_REQUEST;
      r.request.command     = CMD_READ;
      r.request.entry_key   = '1;
      r.request.entry_score = '1;
      r.request.read_index  = index;
      return r;
   endfunction

   function automatic script_row_type capacity_row(input logic [CAP_W-1:0] value);
      script_row_type r;
      r = '0;
      r.kind     = ROW_CAPACITY;
      r.capacity = value;
      return r;
   endfunction

   function automatic script_row_type with_reply(input script_row_type row,
                                                 input logic [RANK_W-1:0] rank,
                                                 input logic [KEY_W-1:0] key,
                                                 input logic signed [SCORE_W-1:0] score,
                                                 input logic valid);
      row.typed             = 1'b1;
      row.reply.placed_rank = rank;
      row.reply.out_key     = key;
      row.reply.out_score   = score;
      row.reply.out_valid   = valid;
      return row;
   endfunction

   initial begin : stimulus
      board_request_type q;
      logic [CAP_W-1:0]  cap;

      for (int i = 0; i < KEY_POOL_SIZE; i++) key_pool[i] = $urandom;
      key_pool[0] = '0;
      key_pool[1] = '1;

      add_row(with_reply(read_row(4'd0), 5'd0, '0, '0, 1'b0));
      add_row(update_row(32'h0000_0001, 16'sd100));
      add_row(with_reply(update_row(32'hFFFF_FFFF, 16'sh7FFF), 5'd0, '0, '0, 1'b0));
      add_row(update_row(32'h0000_0000, 16'sh8000));
      add_row(update_row(32'h0000_0001, 16'sd50));
      add_row(update_row(32'h0000_0002, 16'sd100));
      add_row(update_row(32'h0000_0000, 16'sd200));
      add_row(read_row(4'd1));
      add_row(with_reply(read_row(4'd15), 5'd0, '0, '0, 1'b0));
      add_row(read_row(4'd3));
      add_row(read_row(4'd4));
      add_row(update_row(32'h8000_0000, -16'sd1));
      add_row(capacity_row(5'd2));
      add_row(read_row(4'd2));
      add_row(read_row(4'd1));
      add_row(update_row(32'h0000_0007, 16'sd300));
      add_row(with_reply(update_row(32'h0000_0008, -16'sd5), DROPPED_RANK, '0, '0, 1'b0));
      add_row(update_row(32'h0000_0007, 16'sh7FFF));
      add_row(capacity_row(5'd0));
      add_row(with_reply(update_row(32'h0000_0009, 16'sh7FFF), DROPPED_RANK, '0, '0, 1'b0));
      add_row(with_reply(read_row(4'd0), 5'd0, '0, '0, 1'b0));
      add_row(capacity_row(5'd31));
      add_row(update_row(32'h0000_0003, 16'sd0));
      add_row(capacity_row(5'd1));
      add_row(update_row(32'h0000_0004, 16'sd0));
      add_row(update_row(32'h0000_0003, -16'sd7));
      add_row(update_row(32'h0000_0005, 16'sd1));
      add_row(read_row(4'd0));

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < script_rows; i++) begin
         if (directed_script[i].kind == ROW_CAPACITY)
            write_capacity(directed_script[i].capacity);
         else
            send_request(directed_script[i].request, directed_script[i].typed,
                         directed_script[i].reply);
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase / 3)
            0: begin
               sender_idle_pct   = 32;
               receiver_idle_pct = 58;
            end
            1: begin
               sender_idle_pct   = 58;
               receiver_idle_pct = 32;
            end
            default: begin
               sender_idle_pct   = 0;
               receiver_idle_pct = 0;
            end
         endcase
         case (phase)
            0, 8:    cap = CAP_W'(16);
            1:       cap = CAP_W'(5);
            2:       cap = CAP_W'(31);
            3:       cap = CAP_W'(1);
            4:       cap = CAP_W'(17);
            5:       cap = CAP_W'(10);
            6:       cap = CAP_W'(0);
            default: cap = CAP_W'($urandom_range(31));
         endcase
         write_capacity(cap);
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            // now and then hold off until every transfer has come back
            if ($urandom_range(149) == 0) settle_board();
            q.command   = ($urandom_range(99) < 30) ? CMD_READ : CMD_UPDATE;
            q.entry_key = ($urandom_range(99) < 75) ?
                          key_pool[$urandom_range(KEY_POOL_SIZE - 1)] : $urandom;
            case ($urandom_range(3))
               0:       q.entry_score = SCORE_W'($urandom);
               1:       q.entry_score = SCORE_W'($urandom_range(6)) - SCORE_W'(3);
               2:       q.entry_score = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
               default: q.entry_score = SCORE_W'($urandom_range(400)) - SCORE_W'(200);
            endcase
            q.read_index = IDX_W'($urandom);
            send_request(q, 1'b0, '0);
         end
      end

      settle_board();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
